>>> rtl/imu_gbc_pkg.sv
// Shared types, constants and helpers for the IMU gyro bias calibrator.
package imu_gbc_pkg;

  // Fixed field widths
  localparam int unsigned TickWidth  = 32;
  localparam int unsigned SampWidth  = 16;
  localparam int unsigned RateWidth  = 17;
  localparam int unsigned SumWidth   = 32;
  localparam int unsigned DiffWidth  = 34;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Reset value of the window start and the re-arm delay after a skipped window
  localparam logic [TickWidth-1:0] ResetStartTick = 32'd1000;
  localparam logic [TickWidth-1:0] RestartDelay   = 32'd10;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    RegCalStart  = 3'd0,
    RegUsePreset = 3'd1,
    RegPresetX   = 3'd2,
    RegPresetY   = 3'd3,
    RegPresetZ   = 3'd4
  } cfg_reg_e;

  // Stored configuration used by the datapath
  typedef struct packed {
    logic                        use_preset;
    logic signed [SampWidth-1:0] preset_x;
    logic signed [SampWidth-1:0] preset_y;
    logic signed [SampWidth-1:0] preset_z;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic                        have_new;
    logic [TickWidth-1:0]        tick;
    logic signed [SampWidth-1:0] acc_x;
    logic signed [SampWidth-1:0] acc_y;
    logic signed [SampWidth-1:0] acc_z;
    logic signed [SampWidth-1:0] temp;
    logic signed [SampWidth-1:0] rate_x;
    logic signed [SampWidth-1:0] rate_y;
    logic signed [SampWidth-1:0] rate_z;
  } item_t;

  // One result word
  typedef struct packed {
    logic signed [SampWidth-1:0] acc_x;
    logic signed [SampWidth-1:0] acc_y;
    logic signed [SampWidth-1:0] acc_z;
    logic signed [SampWidth-1:0] temp;
    logic signed [SampWidth-1:0] rate_x;
    logic signed [SampWidth-1:0] rate_y;
    logic signed [SampWidth-1:0] rate_z;
    logic                        calibrated;
  } result_t;

  // Clamp a wide signed difference to 16 bits
  function automatic logic [SampWidth-1:0] sat16(input logic signed [DiffWidth-1:0] v);
    logic [SampWidth-1:0] r;
    if (v > 34'sd32767) begin
      r = 16'h7fff;
    end else if (v < -34'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[SampWidth-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/imu_gbc_div.sv
// Signed divide of the three bias sums by the fixed sample count, by reciprocal multiplication.
module imu_gbc_div #(
  parameter int unsigned SAMPLE_COUNT = 1000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [2:0][imu_gbc_pkg::SumWidth-1:0] sum,
  output logic                                busy,
  output logic                                done,
  output logic [2:0][imu_gbc_pkg::SumWidth-1:0] quot
);
  import imu_gbc_pkg::*;

  // Reciprocal ceil(2^Shift / SAMPLE_COUNT); its error stays below 2^PreShift, so the
  // truncated product equals the quotient for every magnitude below 2^SumWidth
  localparam int unsigned PreShift = $clog2(SAMPLE_COUNT);
  localparam int unsigned Shift    = SumWidth + PreShift;
  localparam logic [63:0] ShiftPow = 64'd1 << Shift;
  localparam logic [63:0] Recip    = (ShiftPow + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
  localparam logic [SumWidth-1:0] RecipLo = Recip[SumWidth-1:0];
  localparam logic                RecipHi = Recip[SumWidth];

  logic                          phase;
  logic [2:0]                    neg;
  logic [2:0][SumWidth-1:0]      mag;
  logic [2:0][2*SumWidth-1:0]    prod;
  logic [2:0][2*SumWidth:0]      full;
  logic [2:0][SumWidth-1:0]      q;

  // Add the top reciprocal bit term, drop the fraction, restore the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = {1'b0, prod[i]} + (RecipHi ? {1'b0, mag[i], SumWidth'(0)} : (2*SumWidth+1)'(0));
      q[i]    = SumWidth'(full[i] >> Shift);
      quot[i] = neg[i] ? (SumWidth'(0) - q[i]) : q[i];
    end
  end

  // Sequencing: a product phase, then a phase with the quotient ready and done raised
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 1'b1;
    end else if (busy) begin
      if (phase) begin
        phase <= 1'b0;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign done = busy && !phase;

  // Magnitudes on start, then the 32 by 32 products
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= sum[i][SumWidth-1];
        mag[i] <= sum[i][SumWidth-1] ? (SumWidth'(0) - sum[i]) : sum[i];
      end
    end
    if (busy && phase) begin
      for (int i = 0; i < 3; i++) begin
        prod[i] <= (2*SumWidth)'(mag[i]) * (2*SumWidth)'(RecipLo);
      end
    end
  end

endmodule

>>> rtl/imu_gbc_core.sv
// Sample hold, bias window tracking, accumulation and offset removal for one word.
module imu_gbc_core #(
  parameter int unsigned SAMPLE_COUNT = 1000
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  imu_gbc_pkg::item_t                    item,
  input  imu_gbc_pkg::cfg_t                     cfg,
  input  logic                                  win_load,
  input  logic [imu_gbc_pkg::TickWidth-1:0]     win_load_val,
  input  logic                                  div_done,
  input  logic [2:0][imu_gbc_pkg::SumWidth-1:0] div_quot,
  output logic                                  div_start,
  output logic [2:0][imu_gbc_pkg::SumWidth-1:0] div_sum,
  output imu_gbc_pkg::result_t                  res
);
  import imu_gbc_pkg::*;

  // Model state
  logic [2:0][SampWidth-1:0] acc_hold;
  logic [SampWidth-1:0]      temp_hold;
  logic [2:0][RateWidth-1:0] rate_hold;
  logic [2:0][SumWidth-1:0]  bias_sum;
  logic                      bias_ready;
  logic [TickWidth-1:0]      window_start;

  logic [2:0][SampWidth-1:0] acc_next;
  logic [SampWidth-1:0]      temp_next;
  logic [2:0][RateWidth-1:0] rate_next;
  logic [2:0][SumWidth-1:0]  sum_add;
  logic [2:0][SumWidth-1:0]  off;
  logic [2:0][SampWidth-1:0] rate_out;
  logic [2:0][SampWidth-1:0] preset;
  logic [TickWidth-1:0]      win_end;
  logic                      subtract;
  logic                      early;
  logic                      in_win;
  logic                      closing;

  // Fresh sample or held one; Y and Z rates are negated
  always_comb begin
    if (item.have_new) begin
      acc_next     = {item.acc_z, item.acc_y, item.acc_x};
      temp_next    = item.temp;
      rate_next[0] = {item.rate_x[SampWidth-1], item.rate_x};
      rate_next[1] = RateWidth'(0) - {item.rate_y[SampWidth-1], item.rate_y};
      rate_next[2] = RateWidth'(0) - {item.rate_z[SampWidth-1], item.rate_z};
    end else begin
      acc_next  = acc_hold;
      temp_next = temp_hold;
      rate_next = rate_hold;
    end
  end

  // Window position of this tick
  assign subtract = cfg.use_preset | bias_ready;
  assign win_end  = window_start + TickWidth'(SAMPLE_COUNT);
  assign early    = (item.tick < window_start);
  assign in_win   = (item.tick <= win_end);
  assign closing  = (item.tick == win_end);
  assign preset   = {cfg.preset_z, cfg.preset_y, cfg.preset_x};

  // Running sums and offset removal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_add[i] = bias_sum[i] + {{(SumWidth-RateWidth){rate_next[i][RateWidth-1]}},
                                  rate_next[i]};
      off[i] = cfg.use_preset ?
               {{(SumWidth-SampWidth){preset[i][SampWidth-1]}}, preset[i]} : bias_sum[i];
      if (subtract) begin
        rate_out[i] = sat16($signed(
          {{(DiffWidth-RateWidth){rate_next[i][RateWidth-1]}}, rate_next[i]} -
          {{(DiffWidth-SumWidth){off[i][SumWidth-1]}}, off[i]}));
      end else begin
        rate_out[i] = sat16($signed(
          {{(DiffWidth-RateWidth){rate_next[i][RateWidth-1]}}, rate_next[i]}));
      end
    end
  end

  assign div_start = adv && !subtract && !early && in_win && closing;
  assign div_sum   = sum_add;

  // Result word
  always_comb begin
    res.acc_x      = acc_next[0];
    res.acc_y      = acc_next[1];
    res.acc_z      = acc_next[2];
    res.temp       = temp_next;
    res.rate_x     = rate_out[0];
    res.rate_y     = rate_out[1];
    res.rate_z     = rate_out[2];
    res.calibrated = subtract;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_hold     <= '0;
      temp_hold    <= '0;
      rate_hold    <= '0;
      bias_sum     <= '0;
      bias_ready   <= 1'b0;
      window_start <= ResetStartTick;
    end else begin
      if (adv) begin
        acc_hold  <= acc_next;
        temp_hold <= temp_next;
        rate_hold <= rate_next;
      end
      if (win_load) begin
        window_start <= win_load_val;
      end else if (adv && !subtract && !early && !in_win) begin
        window_start <= item.tick + RestartDelay;
      end
      if (div_done) begin
        bias_sum <= div_quot;
      end else if (adv && !subtract) begin
        if (early) begin
          bias_sum <= '0;
        end else if (in_win) begin
          bias_sum <= sum_add;
        end
      end
      if (div_start) begin
        bias_ready <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/imu_gyro_bias_calibrator_top.sv
// Top level of the IMU gyro bias calibrator: handshake, configuration and word registers.
// An accepted word is held in the input register, then registered into the result register.
// Throughput: one word per cycle unless the output stalls; the word closing the averaging
// window starts a reciprocal-multiply divide, and the next word waits in the input register.
// Reset (synchronous, active high) empties both word registers, clears held samples and sums,
// sets the window start to tick 1000 and returns the configuration to its defaults.
module imu_gyro_bias_calibrator_top #(
  parameter int unsigned SAMPLE_COUNT = 1000
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // configuration
  input  logic                                       cfg_write,
  input  logic [imu_gbc_pkg::CfgIdxWidth-1:0]        cfg_index,
  input  logic [imu_gbc_pkg::CfgDataWidth-1:0]       cfg_data,
  // input channel
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic                                       have_new,
  input  logic [imu_gbc_pkg::TickWidth-1:0]          tick,
  input  logic signed [imu_gbc_pkg::SampWidth-1:0]   acc_x_in,
  input  logic signed [imu_gbc_pkg::SampWidth-1:0]   acc_y_in,
  input  logic signed [imu_gbc_pkg::SampWidth-1:0]   acc_z_in,
  input  logic signed [imu_gbc_pkg::SampWidth-1:0]   temp_in,
  input  logic signed [imu_gbc_pkg::SampWidth-1:0]   rate_x_in,
  input  logic signed [imu_gbc_pkg::SampWidth-1:0]   rate_y_in,
  input  logic signed [imu_gbc_pkg::SampWidth-1:0]   rate_z_in,
  // output channel
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic signed [imu_gbc_pkg::SampWidth-1:0]   acc_x_out,
  output logic signed [imu_gbc_pkg::SampWidth-1:0]   acc_y_out,
  output logic signed [imu_gbc_pkg::SampWidth-1:0]   acc_z_out,
  output logic signed [imu_gbc_pkg::SampWidth-1:0]   temp_out,
  output logic signed [imu_gbc_pkg::SampWidth-1:0]   rate_x_out,
  output logic signed [imu_gbc_pkg::SampWidth-1:0]   rate_y_out,
  output logic signed [imu_gbc_pkg::SampWidth-1:0]   rate_z_out,
  output logic                                       calibrated
);
  import imu_gbc_pkg::*;

  cfg_t                     cfg;
  item_t                    s1;
  logic                     s1_valid;
  logic                     s1_adv;
  logic                     in_take;
  logic                     win_load;
  result_t                  res;
  result_t                  out_word;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [2:0][SumWidth-1:0] div_sum;
  logic [2:0][SumWidth-1:0] div_quot;

  // Configuration registers
  assign win_load = cfg_write && (cfg_reg_e'(cfg_index) == RegCalStart);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        RegUsePreset: cfg.use_preset <= cfg_data[0];
        RegPresetX:   cfg.preset_x   <= cfg_data[SampWidth-1:0];
        RegPresetY:   cfg.preset_y   <= cfg_data[SampWidth-1:0];
        RegPresetZ:   cfg.preset_z   <= cfg_data[SampWidth-1:0];
        default:      ;
      endcase
    end
  end

  // Handshake: the input register moves on when the divider is idle and the result register is free or draining
  assign s1_adv   = s1_valid && !div_busy && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // Input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1 <= '{have_new: have_new, tick: tick, acc_x: acc_x_in, acc_y: acc_y_in,
              acc_z: acc_z_in, temp: temp_in, rate_x: rate_x_in, rate_y: rate_y_in,
              rate_z: rate_z_in};
    end
  end

  imu_gbc_core #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .adv          (s1_adv),
    .item         (s1),
    .cfg          (cfg),
    .win_load     (win_load),
    .win_load_val (cfg_data[TickWidth-1:0]),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_start    (div_start),
    .div_sum      (div_sum),
    .res          (res)
  );

  imu_gbc_div #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum   (div_sum),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word <= res;
    end
  end

  assign acc_x_out  = out_word.acc_x;
  assign acc_y_out  = out_word.acc_y;
  assign acc_z_out  = out_word.acc_z;
  assign temp_out   = out_word.temp;
  assign rate_x_out = out_word.rate_x;
  assign rate_y_out = out_word.rate_y;
  assign rate_z_out = out_word.rate_z;
  assign calibrated = out_word.calibrated;

endmodule

>>> rtl/imu_gbc_checker.sv
// Port-level checks for the IMU gyro bias calibrator, bound to the top level.
module imu_gbc_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_stall,
  input logic                                     out_valid,
  input logic                                     out_stall,
  input logic signed [imu_gbc_pkg::SampWidth-1:0] rate_x_out,
  input logic signed [imu_gbc_pkg::SampWidth-1:0] rate_y_out,
  input logic signed [imu_gbc_pkg::SampWidth-1:0] rate_z_out,
  input logic                                     calibrated
);
  import imu_gbc_pkg::*;

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its rates and flag
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(rate_x_out) && $stable(rate_y_out) &&
                               $stable(rate_z_out) && $stable(calibrated))
    else $error("result word changed while stalled");

  // Reset leaves no word pending on the output
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  // Reset leaves the input side open
  a_rst_open: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind imu_gyro_bias_calibrator_top imu_gbc_checker u_imu_gbc_checker (.*);
